@@ rtl/core/frt_pkg.sv @@
// package for the fragment reassembly tracker: widths, codes and status types
package frt_pkg;
    localparam int ENTRIES = 8;
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_ORDER    = 3'd3;
    localparam logic [2:0] ST_BADLEN   = 3'd4;
    localparam logic [2:0] ST_POOLFULL = 3'd5;
    localparam logic [2:0] ST_TABLE    = 3'd6;
    localparam logic [2:0] ST_TICK     = 3'd7;

    localparam logic [1:0] CFG_MAX_AGE = 2'd0;
    localparam logic [1:0] CFG_BUF_LIM = 2'd1;
    localparam logic [1:0] CFG_HDR_LEN = 2'd2;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [4:0] MAX_AGE_RST = 5'd21;

    typedef struct packed {
        logic       hit;
        logic       free_found;
        logic [SLOT_W-1:0] hit_slot;
        logic [SLOT_W-1:0] free_slot;
    } scan_t;
endpackage

@@ rtl/core/frt_cfg.sv @@
// configuration registers of the fragment reassembly tracker
module frt_cfg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output logic [4:0] max_age,
    output logic [9:0] buffer_limit,
    output logic [5:0] header_length
);
    import frt_pkg::*;

    logic [4:0] max_age_reg;
    logic [9:0] buf_lim_reg;
    logic [5:0] hdr_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= MAX_AGE_RST;
            buf_lim_reg <= 10'd336;
            hdr_len_reg <= 6'd24;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_AGE: max_age_reg <= cfg_data[4:0];
                CFG_BUF_LIM: buf_lim_reg <= cfg_data[9:0];
                CFG_HDR_LEN: hdr_len_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign max_age = max_age_reg;
    assign buffer_limit = buf_lim_reg;
    assign header_length = hdr_len_reg;
endmodule

@@ rtl/core/fragment_reassembly_tracker_core.sv @@
// fragment reassembly tracker: sequencer, entry table and shared compare unit
//
// in channel (in_valid/in_stall): one item per fragment (kind 0) or aging
// tick (kind 1). out channel (out_valid/out_stall): one result per item.
// cfg channel (cfg_valid/cfg_ready, always ready): register index and data;
// the user writes only while the block is idle; the block does not enforce it.
// a fragment walks the entry table one entry a cycle with a single key
// comparator, then the decide state checks it and updates the chosen entry;
// the result is registered for the out state. a tick walks the table one
// entry a cycle through the same scan state, aging each valid entry and
// freeing those whose age has reached max_age.
// in_stall is high from accept until the result has been taken; the next
// item may be accepted in the cycle after the result leaves.
// if out_stall holds, the result stays registered and the block waits.
// reset clears all valid bits, the pool count and the registers to their
// defaults; no clearing pass is needed.
module fragment_reassembly_tracker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [63:0] src_address,
    input  logic [63:0] dst_address,
    input  logic [7:0]  sequence_number,
    input  logic [12:0] offset_units,
    input  logic        more_fragments,
    input  logic [7:0]  frame_length,
    input  logic [3:0]  buffer_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [2:0]  slot,
    output logic [15:0] total_length,
    output logic [3:0]  expired_count,
    output logic [9:0]  pool_used,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import frt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;

    logic [4:0] max_age;
    logic [9:0] buffer_limit;
    logic [5:0] header_length;

    frt_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .max_age(max_age),
        .buffer_limit(buffer_limit), .header_length(header_length)
    );

    logic [1:0] state_reg;
    logic [SLOT_W:0] idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [63:0] e_src [ENTRIES];
    logic [63:0] e_dst [ENTRIES];
    logic [7:0]  e_seq [ENTRIES];
    logic        e_zero [ENTRIES];
    logic [15:0] e_end [ENTRIES];
    logic [9:0]  e_buf [ENTRIES];
    logic [4:0]  e_age [ENTRIES];
    logic [9:0]  pool_reg;

    logic        kind_reg, last_reg;
    logic [63:0] src_reg, dst_reg;
    logic [7:0]  seq_reg;
    logic [15:0] off_reg;
    logic [7:0]  flen_reg;
    logic [3:0]  bufs_reg;
    scan_t       scan_reg;
    logic [CNT_W-1:0] exp_reg;

    logic [2:0]  st_reg;
    logic [2:0]  slot_reg;
    logic [15:0] tot_reg;

    logic [SLOT_W-1:0] idx;
    logic key_eq;
    logic [9:0] rel_buf;

    assign idx = idx_reg[SLOT_W-1:0];
    assign key_eq = valid_reg[idx] && e_src[idx] == src_reg && e_dst[idx] == dst_reg
                    && e_seq[idx] == seq_reg;
    assign rel_buf = e_buf[idx];

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = st_reg;
    assign slot = slot_reg;
    assign total_length = tot_reg;
    assign expired_count = 4'(exp_reg);
    assign pool_used = pool_reg;

    logic [SLOT_W-1:0] sel;
    logic [7:0]  payload;
    logic [16:0] end_w;
    logic [10:0] pool_sum;
    logic [9:0]  newbuf;
    logic [9:0]  rel_after;
    logic [2:0]  dec_st;
    logic [2:0]  dec_slot;
    logic [15:0] dec_tot;
    logic        dec_upd;

    always_comb
    begin
        sel = scan_reg.hit ? scan_reg.hit_slot : scan_reg.free_slot;
        payload = flen_reg - {2'b00, header_length};
        end_w = {1'b0, off_reg} + {9'd0, payload};
        pool_sum = {1'b0, pool_reg} + {7'd0, bufs_reg};
        newbuf = (scan_reg.hit ? e_buf[sel] : 10'd0) + {6'd0, bufs_reg};
        rel_after = (pool_sum[9:0] >= newbuf) ? pool_sum[9:0] - newbuf : 10'd0;
    end

    always_comb
    begin
        dec_st = ST_PENDING;
        dec_slot = 3'd0;
        dec_tot = 16'd0;
        dec_upd = 1'b0;
        if (kind_reg)
            dec_st = ST_TICK;
        else if (flen_reg <= {2'b00, header_length})
            dec_st = ST_BADLEN;
        else if (pool_sum > {1'b0, buffer_limit})
            dec_st = ST_POOLFULL;
        else if (!scan_reg.hit && !scan_reg.free_found)
            dec_st = ST_TABLE;
        else
        begin
            dec_slot = 3'(sel);
            if (last_reg && end_w > {1'b0, LEN_MAX - {10'd0, header_length}})
                dec_st = ST_BADLEN;
            else if (!scan_reg.hit && last_reg && off_reg != 16'd0)
                dec_st = ST_ORDER;
            else if (scan_reg.hit && off_reg < e_end[sel])
                dec_st = ST_OVERLAP;
            else if (scan_reg.hit && off_reg > e_end[sel])
                dec_st = ST_ORDER;
            else if (scan_reg.hit && last_reg && !e_zero[sel])
                dec_st = ST_ORDER;
            else
            begin
                dec_upd = 1'b1;
                if (last_reg)
                begin
                    dec_st = ST_COMPLETE;
                    dec_tot = end_w[15:0] + {10'd0, header_length};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            pool_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg <= kind;
                        src_reg <= src_address;
                        dst_reg <= dst_address;
                        seq_reg <= sequence_number;
                        off_reg <= {1'b0, offset_units, 2'b00};
                        last_reg <= !more_fragments;
                        flen_reg <= frame_length;
                        bufs_reg <= buffer_count;
                        scan_reg <= '0;
                        exp_reg <= '0;
                        idx_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (kind_reg)
                    begin
                        if (valid_reg[idx])
                        begin
                            if (e_age[idx] < max_age)
                                e_age[idx] <= e_age[idx] + 5'd1;
                            else
                            begin
                                valid_reg[idx] <= 1'b0;
                                pool_reg <= (pool_reg >= rel_buf) ? pool_reg - rel_buf : 10'd0;
                                exp_reg <= exp_reg + CNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        if (key_eq && !scan_reg.hit)
                        begin
                            scan_reg.hit <= 1'b1;
                            scan_reg.hit_slot <= idx;
                        end
                        if (!valid_reg[idx] && !scan_reg.free_found)
                        begin
                            scan_reg.free_found <= 1'b1;
                            scan_reg.free_slot <= idx;
                        end
                    end
                    if (idx_reg == (SLOT_W + 1)'(ENTRIES - 1))
                        state_reg <= S_DECIDE;
                    idx_reg <= idx_reg + (SLOT_W + 1)'(1);
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT;
                    st_reg <= dec_st;
                    slot_reg <= dec_slot;
                    tot_reg <= dec_tot;
                    if (dec_upd)
                    begin
                        if (!scan_reg.hit)
                        begin
                            e_src[sel] <= src_reg;
                            e_dst[sel] <= dst_reg;
                            e_seq[sel] <= seq_reg;
                            e_zero[sel] <= (off_reg == 16'd0);
                            e_age[sel] <= 5'd0;
                        end
                        e_end[sel] <= end_w[15:0];
                        e_buf[sel] <= newbuf;
                        valid_reg[sel] <= !last_reg;
                        pool_reg <= last_reg ? rel_after : pool_sum[9:0];
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
